/* design/route_constrained_shortest_path_top_assert.svh */
// ----------------------------------------------------------------------------
// Route-constrained shortest path: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ROUTE_CONSTRAINED_SHORTEST_PATH_TOP_ASSERT_SVH
`define ROUTE_CONSTRAINED_SHORTEST_PATH_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define RCSP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RCSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/rcsp_pkg.sv */
// ----------------------------------------------------------------------------
// rcsp_pkg
// Shared constants, operation codes, state type and queue control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsp_pkg;

   localparam int MAX_NODES_DEF   = 256;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int DIST_BITS_DEF   = 32;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_SOLVE  = 2'd2;

   localparam logic CSR_NODE_COUNT = 1'b0;
   localparam logic CSR_ROUTE_LEN  = 1'b1;

   localparam logic [8:0] NODE_COUNT_RST = 9'd256;
   localparam logic [8:0] ROUTE_LEN_RST  = 9'd1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_INS2,
      S_POP,
      S_POPW,
      S_DI,
      S_SCAN,
      S_FINISH,
      S_FINW
   } rcsp_state_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } rcsp_qctl_type;

endpackage

`default_nettype wire

/* design/rcsp_ram.sv */
// ----------------------------------------------------------------------------
// rcsp_ram
// Simple dual-port synchronous RAM with one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsp_ram #(
   parameter int ADDR_BITS = 8,
   parameter int DATA_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [DATA_BITS-1:0] wdata,
   input  wire logic                 re,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output logic      [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

/* design/rcsp_queue.sv */
// ----------------------------------------------------------------------------
// rcsp_queue
// Circular work queue of node indexes held in a RAM, with head and count.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsp_queue import rcsp_pkg::*; #(
   parameter int DEPTH = MAX_NODES_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire rcsp_qctl_type ctl,
   input  wire logic [AW-1:0] push_node,
   output logic      [AW-1:0] pop_node,
   output logic               empty
);

   logic [AW-1:0] head_ff, head_in;
   logic [AW:0]   count_ff, count_in;
   logic [AW:0]   tail_sum;
   logic [AW-1:0] tail;
   logic [AW-1:0] waddr;

   // The ring wraps at DEPTH, which need not be a power of two.
   always_comb begin
      tail_sum = (AW+1)'(head_ff) + count_ff;
      if (tail_sum >= (AW+1)'(DEPTH)) begin
         tail = AW'(tail_sum - (AW+1)'(DEPTH));
      end else begin
         tail = tail_sum[AW-1:0];
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      waddr    = tail;
      if (ctl.clear) begin
         head_in  = '0;
         count_in = ctl.push ? (AW+1)'(1) : '0;
         waddr    = '0;
      end else begin
         if (ctl.pop) begin
            head_in  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
            count_in = count_ff - (AW+1)'(1);
         end
         if (ctl.push) begin
            count_in = count_ff + (AW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   assign empty = (count_ff == '0);

   rcsp_ram #(
      .ADDR_BITS(AW),
      .DATA_BITS(AW)
   ) u_ring (
      .clock(clock),
      .we   (ctl.push),
      .waddr(waddr),
      .wdata(push_node),
      .re   (ctl.pop),
      .raddr(head_ff),
      .rdata(pop_node)
   );

endmodule

`default_nettype wire

/* design/route_constrained_shortest_path_top.sv */
// ----------------------------------------------------------------------------
// route_constrained_shortest_path_top
// Edge matrix in RAM with route-rule insertion and a queue-driven
// Bellman-Ford relaxation that reports the cost to the last route node.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake       | Beat contents
//   --------+-----------+-----------------+---------------------------------
//   req_    | in        | valid / stall   | op, node_a, node_b, weight, source
//   rsp_    | out       | valid / stall   | distance, unreachable
//   csr_    | in        | write, no wait  | index, wdata
//
// An insert beat writes the edge in S_IDLE, and the reverse direction in
// S_INS2 when the edge is stored both ways. A clear beat, and reset, sweep
// the whole edge RAM of 2^(2*clog2(MAX_NODES)) entries, 65536 at the default
// size, at one entry per cycle. A solve pops each queued node through S_POP,
// S_POPW and S_DI, then scans the nodes in use in S_SCAN; the single read port
// of the edge RAM scans one neighbor per cycle. The result sits in an output
// register; a solve ending while the last result is stalled waits in S_FINW.
// ----------------------------------------------------------------------------
`default_nettype none

module route_constrained_shortest_path_top import rcsp_pkg::*; #(
   parameter int MAX_NODES   = MAX_NODES_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   parameter int DIST_BITS   = DIST_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [7:0]  req_node_a,
   input  wire logic [7:0]  req_node_b,
   input  wire logic [15:0] req_weight,
   input  wire logic [7:0]  req_source,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_distance,
   output logic             rsp_unreachable,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [8:0]  csr_wdata
);

   localparam int NW  = $clog2(MAX_NODES);
   localparam int KW  = (NW + 1 > 9) ? NW + 1 : 9;
   localparam int EW  = 2 * NW;
   localparam int EDW = WEIGHT_BITS + 1;
   localparam int SW  = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
   localparam logic [DIST_BITS-1:0] DMAX = '1;

   rcsp_state_type state_ff, state_in;

   logic [EW-1:0]          sweep_ff, sweep_in;
   logic [8:0]             node_count_ff, route_len_ff;
   logic [MAX_NODES-1:0]   reached_ff, reached_in;
   logic [MAX_NODES-1:0]   inq_ff, inq_in;
   logic [NW-1:0]          i_ff, i_in;
   logic [KW-1:0]          j_ff, j_in;
   logic                   pv_ff, pv_in;
   logic [NW-1:0]          pj_ff, pj_in;
   logic [DIST_BITS-1:0]   di_ff, di_in;
   logic [7:0]             src_ff, src_in;
   logic                   src_ok_ff, src_ok_in;
   logic [NW-1:0]          ins_a_ff, ins_a_in, ins_b_ff, ins_b_in;
   logic [WEIGHT_BITS-1:0] ins_w_ff, ins_w_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DIST_BITS-1:0]   rsp_dist_ff, rsp_dist_in;
   logic                   rsp_unr_ff, rsp_unr_in;

   logic                   e_we, e_re;
   logic [EW-1:0]          e_waddr, e_raddr;
   logic [EDW-1:0]         e_wdata, e_rdata;
   logic                   d_we, d_re;
   logic [NW-1:0]          d_waddr, d_raddr;
   logic [DIST_BITS-1:0]   d_wdata, d_rdata;
   rcsp_qctl_type          qctl;
   logic [NW-1:0]          q_push_node, q_pop_node;
   logic                   q_empty;

   logic                   req_accept, slot_free, scan_more;
   logic [KW-1:0]          n_cnt, a_k, b_k, c_k, src_k, dest_k;
   logic [8:0]             dest9;
   logic                   a_route, b_route, adjacent, pair_ok, do_ab, do_ba;
   logic                   src_in_range;
   logic [WEIGHT_BITS-1:0] w_in;
   logic [SW-1:0]          sum;
   logic [DIST_BITS-1:0]   cand;
   logic                   upd;
   logic [63:0]            rsp_ext;

   // ---------------------------------------------------------------- decode
   always_comb begin
      n_cnt = (KW'(node_count_ff) > KW'(MAX_NODES)) ? KW'(MAX_NODES)
                                                   : KW'(node_count_ff);
      a_k      = KW'(req_node_a);
      b_k      = KW'(req_node_b);
      c_k      = KW'(route_len_ff);
      src_k    = KW'(req_source);
      dest9    = route_len_ff - 9'd1;
      dest_k   = KW'(dest9);
      a_route  = a_k < c_k;
      b_route  = b_k < c_k;
      adjacent = (a_k + KW'(1) == b_k) || (b_k + KW'(1) == a_k);
      pair_ok  = (a_k < n_cnt) && (b_k < n_cnt);
      // A pair of route nodes is kept both ways only when adjacent; a mixed
      // pair keeps only the direction into the route node.
      do_ab    = pair_ok && (!a_route || (b_route && adjacent));
      do_ba    = pair_ok && (!b_route || (a_route && adjacent));
      w_in     = WEIGHT_BITS'(req_weight);
      src_in_range = src_k < n_cnt;
      scan_more    = j_ff < n_cnt;
      req_accept   = req_valid && !req_stall;
      slot_free    = !rsp_valid_ff || !rsp_stall;

      sum  = SW'(di_ff) + SW'(e_rdata[WEIGHT_BITS-1:0]);
      cand = (sum > SW'(DMAX)) ? DMAX : sum[DIST_BITS-1:0];
      upd  = pv_ff && e_rdata[WEIGHT_BITS] &&
             (!reached_ff[pj_ff] || (cand < d_rdata));
   end

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sweep_ff == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  OP_CLEAR:  state_in = S_CLEAR;
                  OP_INSERT: if (do_ab && do_ba) state_in = S_INS2;
                  OP_SOLVE:  state_in = src_in_range ? S_POP : S_FINISH;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_INS2:   state_in = S_IDLE;
         S_POP:    state_in = q_empty ? S_FINISH : S_POPW;
         S_POPW:   state_in = S_DI;
         S_DI:     state_in = S_SCAN;
         S_SCAN: begin
            if (!scan_more && !pv_ff) state_in = S_POP;
         end
         S_FINISH: state_in = S_FINW;
         S_FINW: begin
            if (slot_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // --------------------------------------------------------------- outputs
   always_comb begin
      req_stall   = (state_ff != S_IDLE);
      sweep_in    = sweep_ff;
      reached_in  = reached_ff;
      inq_in      = inq_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      pv_in       = 1'b0;
      pj_in       = pj_ff;
      di_in       = di_ff;
      src_in      = src_ff;
      src_ok_in   = src_ok_ff;
      ins_a_in    = ins_a_ff;
      ins_b_in    = ins_b_ff;
      ins_w_in    = ins_w_ff;
      rsp_dist_in = rsp_dist_ff;
      rsp_unr_in  = rsp_unr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      e_we        = 1'b0;
      e_waddr     = sweep_ff;
      e_wdata     = '0;
      e_re        = 1'b0;
      e_raddr     = {i_ff, j_ff[NW-1:0]};
      d_we        = 1'b0;
      d_waddr     = pj_ff;
      d_wdata     = cand;
      d_re        = 1'b0;
      d_raddr     = j_ff[NW-1:0];
      qctl        = '0;
      q_push_node = pj_ff;

      case (state_ff)
         S_CLEAR: begin
            e_we     = 1'b1;
            sweep_in = sweep_ff + EW'(1);
         end
         S_IDLE: begin
            sweep_in = '0;
            if (req_accept) begin
               case (req_op)
                  OP_INSERT: begin
                     ins_a_in = a_k[NW-1:0];
                     ins_b_in = b_k[NW-1:0];
                     ins_w_in = w_in;
                     e_we     = do_ab || do_ba;
                     e_waddr  = do_ab ? {a_k[NW-1:0], b_k[NW-1:0]}
                                      : {b_k[NW-1:0], a_k[NW-1:0]};
                     e_wdata  = {1'b1, w_in};
                  end
                  OP_SOLVE: begin
                     src_in     = req_source;
                     src_ok_in  = src_in_range;
                     reached_in = '0;
                     inq_in     = '0;
                     qctl.clear = 1'b1;
                     if (src_in_range) begin
                        d_we        = 1'b1;
                        d_waddr     = src_k[NW-1:0];
                        d_wdata     = '0;
                        reached_in[src_k[NW-1:0]] = 1'b1;
                        inq_in[src_k[NW-1:0]]     = 1'b1;
                        qctl.push   = 1'b1;
                        q_push_node = src_k[NW-1:0];
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_INS2: begin
            e_we    = 1'b1;
            e_waddr = {ins_b_ff, ins_a_ff};
            e_wdata = {1'b1, ins_w_ff};
         end
         S_POP: begin
            qctl.pop = !q_empty;
         end
         S_POPW: begin
            i_in               = q_pop_node;
            inq_in[q_pop_node] = 1'b0;
            d_re               = 1'b1;
            d_raddr            = q_pop_node;
         end
         S_DI: begin
            di_in = d_rdata;
            j_in  = '0;
         end
         S_SCAN: begin
            // Issue neighbor j while the previous neighbor is relaxed; the
            // two always name different nodes, so the RAM needs no forwarding.
            if (scan_more) begin
               e_re  = 1'b1;
               d_re  = 1'b1;
               j_in  = j_ff + KW'(1);
               pj_in = j_ff[NW-1:0];
               pv_in = 1'b1;
            end
            if (upd) begin
               d_we              = 1'b1;
               reached_in[pj_ff] = 1'b1;
               if (!inq_ff[pj_ff]) begin
                  qctl.push     = 1'b1;
                  inq_in[pj_ff] = 1'b1;
               end
            end
         end
         S_FINISH: begin
            d_re    = 1'b1;
            d_raddr = dest_k[NW-1:0];
         end
         S_FINW: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (!src_ok_ff) begin
                  rsp_dist_in = (KW'(src_ff) == dest_k) ? '0 : DMAX;
                  rsp_unr_in  = (KW'(src_ff) != dest_k);
               end else if ((dest_k < n_cnt) && reached_ff[dest_k[NW-1:0]]) begin
                  rsp_dist_in = d_rdata;
                  rsp_unr_in  = 1'b0;
               end else begin
                  rsp_dist_in = DMAX;
                  rsp_unr_in  = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         sweep_ff      <= '0;
         node_count_ff <= NODE_COUNT_RST;
         route_len_ff  <= ROUTE_LEN_RST;
         reached_ff    <= '0;
         inq_ff        <= '0;
         pv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         reached_ff   <= reached_in;
         inq_ff       <= inq_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && (csr_index == CSR_NODE_COUNT)) begin
            node_count_ff <= csr_wdata;
         end
         if (csr_write && (csr_index == CSR_ROUTE_LEN)) begin
            route_len_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      pj_ff       <= pj_in;
      di_ff       <= di_in;
      src_ff      <= src_in;
      src_ok_ff   <= src_ok_in;
      ins_a_ff    <= ins_a_in;
      ins_b_ff    <= ins_b_in;
      ins_w_ff    <= ins_w_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_unr_ff  <= rsp_unr_in;
   end

   assign rsp_ext         = 64'(rsp_dist_ff);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance    = rsp_ext[31:0];
   assign rsp_unreachable = rsp_unr_ff;

   // -------------------------------------------------------------- storage
   rcsp_ram #(
      .ADDR_BITS(EW),
      .DATA_BITS(EDW)
   ) u_edge_ram (
      .clock(clock),
      .we   (e_we),
      .waddr(e_waddr),
      .wdata(e_wdata),
      .re   (e_re),
      .raddr(e_raddr),
      .rdata(e_rdata)
   );

   rcsp_ram #(
      .ADDR_BITS(NW),
      .DATA_BITS(DIST_BITS)
   ) u_dist_ram (
      .clock(clock),
      .we   (d_we),
      .waddr(d_waddr),
      .wdata(d_wdata),
      .re   (d_re),
      .raddr(d_raddr),
      .rdata(d_rdata)
   );

   rcsp_queue #(
      .DEPTH(MAX_NODES)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctl      (qctl),
      .push_node(q_push_node),
      .pop_node (q_pop_node),
      .empty    (q_empty)
   );

endmodule

`default_nettype wire

/* design/rcsp_checker.sv */
// ----------------------------------------------------------------------------
// rcsp_checker
// Port-level checks on the shortest path block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "route_constrained_shortest_path_top_assert.svh"

module rcsp_checker import rcsp_pkg::*; #(
   parameter int DIST_BITS = DIST_BITS_DEF
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_op,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_distance,
   input wire logic        rsp_unreachable
);

   localparam logic [63:0] DMAX64 = (64'd1 << DIST_BITS) - 64'd1;

   `RCSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_distance), "stalled result beat changed")
   `RCSP_ASSERT_SAME(a_unreach_max, rsp_valid && rsp_unreachable, rsp_distance == DMAX64[31:0], "unreachable result without saturated distance")
   `RCSP_ASSERT_SAME(a_rsp_after_work, $rose(rsp_valid), $past(req_stall), "result appeared without a solve in progress")
   `RCSP_ASSERT_NEXT(a_busy_after_op, req_valid && !req_stall && (req_op == OP_CLEAR || req_op == OP_SOLVE), req_stall, "clear or solve beat did not hold off input")

endmodule

bind route_constrained_shortest_path_top rcsp_checker u_checker (.*);

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Route-constrained shortest path testbench
// Drives clear, insert and solve beats through the valid/stall request
// channel across several node-count and route-length settings. A scoreboard
// keeps its own edge matrix and queue-based relaxation, and checks every
// result beat field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import rcsp_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam longint unsigned DIST_SAT = 64'hFFFF_FFFF;

   class path_scoreboard;
      bit              edge_ok[256][256];
      bit [15:0]       edge_w[256][256];
      int unsigned     node_cnt = 256;
      int unsigned     route_cnt = 1;
      bit [31:0]       exp_dist[$];
      bit              exp_unreach[$];
      int              errors = 0;

      function void set_reg(bit idx, bit [8:0] val);
         if (idx == CSR_NODE_COUNT) node_cnt = val;
         else route_cnt = val;
      endfunction

      function int unsigned nodes_used();
         return (node_cnt > 256) ? 256 : node_cnt;
      endfunction

      function void put_edge(int unsigned f, int unsigned t, bit [15:0] w);
         edge_ok[f][t] = 1'b1;
         edge_w[f][t] = w;
      endfunction

      function void insert_edge(int unsigned u, int unsigned v, bit [15:0] w);
         int unsigned n;
         bit u_rt, v_rt;
         n = nodes_used();
         if (u >= n || v >= n) return;
         u_rt = u < route_cnt;
         v_rt = v < route_cnt;
         if (!u_rt && !v_rt) begin
            put_edge(u, v, w);
            put_edge(v, u, w);
         end else if (!u_rt) begin
            put_edge(u, v, w);
         end else if (!v_rt) begin
            put_edge(v, u, w);
         end else if (u + 1 == v || v + 1 == u) begin
            put_edge(u, v, w);
            put_edge(v, u, w);
         end
      endfunction

      function void solve_from(int unsigned src);
         longint unsigned node_dist[256];
         bit              reached[256];
         bit              queued[256];
         int unsigned     work[$];
         int unsigned     n, dest, i;
         longint unsigned cand;
         n = nodes_used();
         dest = (route_cnt + 511) & 511;
         if (src >= n) begin
            exp_dist.push_back(src == dest ? 32'd0 : DIST_SAT[31:0]);
            exp_unreach.push_back(src != dest);
            return;
         end
         foreach (node_dist[k]) begin
            node_dist[k] = DIST_SAT;
            reached[k] = 1'b0;
            queued[k] = 1'b0;
         end
         node_dist[src] = 0;
         reached[src] = 1'b1;
         queued[src] = 1'b1;
         work.push_back(src);
         while (work.size() > 0) begin
            i = work.pop_front();
            queued[i] = 1'b0;
            for (int unsigned j = 0; j < n; j++) begin
               if (!edge_ok[i][j]) continue;
               cand = node_dist[i] + edge_w[i][j];
               if (cand > DIST_SAT) cand = DIST_SAT;
               if (!reached[j] || cand < node_dist[j]) begin
                  node_dist[j] = cand;
                  reached[j] = 1'b1;
                  if (!queued[j]) begin
                     queued[j] = 1'b1;
                     work.push_back(j);
                  end
               end
            end
         end
         if (dest < n && reached[dest]) begin
            exp_dist.push_back(node_dist[dest][31:0]);
            exp_unreach.push_back(1'b0);
         end else begin
            exp_dist.push_back(DIST_SAT[31:0]);
            exp_unreach.push_back(1'b1);
         end
      endfunction

      function void note_beat(bit [1:0] op, bit [7:0] a, bit [7:0] b, bit [15:0] w,
                              bit [7:0] src);
         case (op)
            OP_CLEAR: begin
               foreach (edge_ok[x, y]) edge_ok[x][y] = 1'b0;
            end
            OP_INSERT: insert_edge(a, b, w);
            OP_SOLVE: solve_from(src);
            default: ;
         endcase
      endfunction

      function void check_result(bit [31:0] got_dist, bit unreach);
         bit [31:0] ed;
         bit        eu;
         if (exp_dist.size() == 0) begin
            $error("result beat with no expectation: distance %0d unreachable %0d",
                   got_dist, unreach);
            errors++;
            return;
         end
         ed = exp_dist.pop_front();
         eu = exp_unreach.pop_front();
         if (got_dist !== ed) begin
            $error("distance: expected %0d, actual %0d", ed, got_dist);
            errors++;
         end
         if (unreach !== eu) begin
            $error("unreachable: expected %0d, actual %0d", eu, unreach);
            errors++;
         end
      endfunction

      function int pending();
         return exp_dist.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_CLEAR;
   logic [7:0]  req_node_a = '0;
   logic [7:0]  req_node_b = '0;
   logic [15:0] req_weight = '0;
   logic [7:0]  req_source = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_distance;
   logic        rsp_unreachable;
   logic        csr_write = 1'b0;
   logic        csr_index = CSR_NODE_COUNT;
   logic [8:0]  csr_wdata = '0;

   path_scoreboard sb = new();
   int  idle_mode = 0;
   bit  hold_rsp = 1'b0;
   int  hold_left = 0;
   int  quiet_cycles = 0;

   route_constrained_shortest_path_top u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result side: check, pick the next stall level, and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_distance, rsp_unreachable);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("route_constrained_shortest_path_top regression: fail");
            $finish;
         end
         if (hold_rsp && hold_left == 0) begin
            hold_left <= 3000;
            hold_rsp <= 1'b0;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= (hold_left > 1);
         end else if (idle_mode == 2 || idle_mode == 3) begin
            rsp_stall <= ($urandom_range(0, 99) < (idle_mode == 2 ? 65 : 25));
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_beat(bit [1:0] op, bit [7:0] a, bit [7:0] b, bit [15:0] w,
                            bit [7:0] src);
      int gap;
      gap = 0;
      if (idle_mode == 1 && $urandom_range(0, 99) < 65) gap = $urandom_range(1, 4);
      if (idle_mode == 3 && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_node_a <= a;
      req_node_b <= b;
      req_weight <= w;
      req_source <= src;
      do @(posedge clock); while (req_stall);
      sb.note_beat(op, a, b, w, src);
   endtask

   task automatic write_reg(bit idx, bit [8:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   // The last beat of a phase is a solve; once its result is back, every
   // earlier beat has been fully processed and the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic bit [7:0] pick_node();
      int unsigned lim;
      lim = sb.nodes_used();
      if (lim > 32) lim = 16;
      if (lim == 0 || $urandom_range(0, 99) < 15) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, lim - 1));
   endfunction

   task automatic random_beats(int count);
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 3)
            send_beat(2'd3, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
         else if (r < 18)
            send_beat(OP_SOLVE, 8'($urandom), 8'($urandom), 16'($urandom), pick_node());
         else
            send_beat(OP_INSERT, pick_node(), pick_node(), 16'($urandom), 8'($urandom));
      end
      send_beat(OP_SOLVE, 0, 0, 0, pick_node());
   endtask

   int phase_nc[7]  = '{256, 16, 1, 511, 4, 32, 24};
   int phase_rl[7]  = '{256, 0, 1, 3, 10, 16, 2};
   int phase_len[7] = '{40, 100, 40, 30, 60, 120, 100};

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_reg(CSR_NODE_COUNT, 9'd8);
      write_reg(CSR_ROUTE_LEN, 9'd4);

      // Route rule corners, range checks, self loop, unused op, extremes.
      send_beat(OP_CLEAR, 0, 0, 0, 0);
      send_beat(OP_INSERT, 0, 1, 16'd0, 0);
      send_beat(OP_INSERT, 1, 2, 16'hFFFF, 0);
      send_beat(OP_INSERT, 2, 3, 16'd7, 0);
      send_beat(OP_INSERT, 5, 1, 16'd3, 0);
      send_beat(OP_INSERT, 1, 5, 16'd9, 0);
      send_beat(OP_INSERT, 0, 2, 16'd1, 0);
      send_beat(OP_INSERT, 5, 6, 16'd100, 0);
      send_beat(OP_INSERT, 6, 6, 16'd4, 0);
      send_beat(OP_INSERT, 9, 3, 16'd1, 0);
      send_beat(OP_INSERT, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
      send_beat(2'd3, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
      send_beat(OP_SOLVE, 0, 0, 0, 8'd0);
      send_beat(OP_SOLVE, 0, 0, 0, 8'd5);
      send_beat(OP_SOLVE, 0, 0, 0, 8'd6);
      send_beat(OP_SOLVE, 0, 0, 0, 8'd7);
      send_beat(OP_SOLVE, 0, 0, 0, 8'd3);
      send_beat(OP_SOLVE, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
      random_beats(230);
      drain();

      for (int p = 0; p < 7; p++) begin
         idle_mode = (p + 1) % 4;
         write_reg(CSR_NODE_COUNT, 9'(phase_nc[p]));
         write_reg(CSR_ROUTE_LEN, 9'(phase_rl[p]));
         if (p == 5) hold_rsp = 1'b1;
         if (p == 1 || p == 5) send_beat(OP_CLEAR, 0, 0, 0, 0);
         // Source beyond the node count that is itself the destination.
         if (p == 4) send_beat(OP_SOLVE, 0, 0, 0, 8'd9);
         random_beats(phase_len[p]);
         drain();
      end

      idle_mode = 0;
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("route_constrained_shortest_path_top regression: pass");
      else
         $display("route_constrained_shortest_path_top regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
+incdir+design
design/rcsp_pkg.sv
design/rcsp_ram.sv
design/rcsp_queue.sv
design/route_constrained_shortest_path_top.sv
design/rcsp_checker.sv
tb/sv/tb.sv
